// ----- hdl/ucdc_pkg.sv -----
// ----------------------------------------------------------------------------
// ucdc_pkg
// types, codes and descriptor rom shared by the cdc control responder
// ----------------------------------------------------------------------------
package ucdc_pkg;

    localparam int CTRL_PACKET_BYTES = 8;
    localparam int NUM_ENDPOINTS     = 4;
    localparam int DESC_ROM_BYTES    = 256;
    localparam int EP_W              = $clog2(NUM_ENDPOINTS);
    localparam int ROM_AW            = $clog2(DESC_ROM_BYTES);

    typedef enum logic [1:0] {
        ACT_DATA  = 2'd0,
        ACT_ZLP   = 2'd1,
        ACT_STALL = 2'd2,
        ACT_RESET = 2'd3
    } t_action;

    // register indexes of the configuration port
    typedef enum logic [1:0] {
        REG_BAUD   = 2'd0,
        REG_STOP   = 2'd1,
        REG_PARITY = 2'd2,
        REG_DBITS  = 2'd3
    } t_reg_index;

    // request keys: bRequest in high byte, bmRequestType in low byte
    localparam logic [15:0] KEY_GET_DESC   = 16'h0680;
    localparam logic [15:0] KEY_SET_ADDR   = 16'h0500;
    localparam logic [15:0] KEY_SET_CONFIG = 16'h0900;
    localparam logic [15:0] KEY_GET_CONFIG = 16'h0880;
    localparam logic [15:0] KEY_GST_DEV    = 16'h0080;
    localparam logic [15:0] KEY_GST_IF     = 16'h0081;
    localparam logic [15:0] KEY_GST_EP     = 16'h0082;
    localparam logic [15:0] KEY_SF_DEV     = 16'h0300;
    localparam logic [15:0] KEY_CF_DEV     = 16'h0100;
    localparam logic [15:0] KEY_SF_IF      = 16'h0301;
    localparam logic [15:0] KEY_CF_IF      = 16'h0101;
    localparam logic [15:0] KEY_SF_EP      = 16'h0302;
    localparam logic [15:0] KEY_CF_EP      = 16'h0102;
    localparam logic [15:0] KEY_SET_LC     = 16'h2021;
    localparam logic [15:0] KEY_GET_LC     = 16'h21A1;
    localparam logic [15:0] KEY_SET_CLS    = 16'h2221;

    localparam logic [15:0] DESC_DEV  = 16'h0100;
    localparam logic [15:0] DESC_CFG  = 16'h0200;
    localparam logic [15:0] DESC_LANG = 16'h0300;
    localparam logic [15:0] DESC_MFR  = 16'h0301;
    localparam logic [15:0] DESC_PROD = 16'h0302;

    localparam logic [ROM_AW-1:0] OFS_DEV  = ROM_AW'(0);
    localparam logic [ROM_AW-1:0] OFS_CFG  = ROM_AW'(18);
    localparam logic [ROM_AW-1:0] OFS_LANG = ROM_AW'(85);
    localparam logic [ROM_AW-1:0] OFS_MFR  = ROM_AW'(89);
    localparam logic [ROM_AW-1:0] OFS_PROD = ROM_AW'(115);
    localparam logic [6:0] LEN_DEV  = 7'd18;
    localparam logic [6:0] LEN_CFG  = 7'd67;
    localparam logic [6:0] LEN_LANG = 7'd4;
    localparam logic [6:0] LEN_MFR  = 7'd26;
    localparam logic [6:0] LEN_PROD = 7'd22;
    localparam logic [6:0] LEN_LC   = 7'd7;

    // data source of a job
    typedef enum logic [1:0] {
        SRC_NONE = 2'd0,
        SRC_ROM  = 2'd1,
        SRC_BUF  = 2'd2
    } t_source;

    typedef struct packed {
        logic [0:0]  command;
        logic [7:0]  request_type;
        logic [7:0]  request_code;
        logic [15:0] request_value;
        logic [15:0] request_index;
        logic [15:0] request_length;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  action;
        logic [63:0] packet_data;
        logic [3:0]  packet_bytes;
        logic [0:0]  last;
        logic [6:0]  device_address;
        logic [7:0]  configuration_value;
        logic [7:0]  control_line_state;
    } t_out_item;

    // classified job passed from front to back
    typedef struct packed {
        t_action           action;
        t_source           source;
        logic [ROM_AW-1:0] offset;
        logic [6:0]        count;
        logic [55:0]       buf_data;
        logic [6:0]        device_address;
        logic [7:0]        configuration_value;
        logic [7:0]        control_line_state;
    } t_job;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_LOAD,
        BK_FETCH,
        BK_SEND
    } t_back_state;

    function automatic logic [7:0] rom_byte(input logic [ROM_AW-1:0] a);
        logic [7:0] d;
        d = 8'h00;
        case (int'(a))
            0: d = 8'h12; 1: d = 8'h01; 2: d = 8'h10; 3: d = 8'h01; 4: d = 8'h02;
            5: d = 8'h00; 6: d = 8'h00; 7: d = 8'h08; 8: d = 8'h40; 9: d = 8'h1C;
            10: d = 8'h37; 11: d = 8'h05; 12: d = 8'h01; 13: d = 8'h00;
            14: d = 8'h01; 15: d = 8'h02; 16: d = 8'h00; 17: d = 8'h01;
            18: d = 8'h09; 19: d = 8'h02; 20: d = 8'h43; 21: d = 8'h00;
            22: d = 8'h02; 23: d = 8'h01; 24: d = 8'h00; 25: d = 8'hC0;
            26: d = 8'hC8;
            27: d = 8'h09; 28: d = 8'h04; 29: d = 8'h00; 30: d = 8'h00;
            31: d = 8'h01; 32: d = 8'h02; 33: d = 8'h02; 34: d = 8'h00;
            35: d = 8'h00;
            36: d = 8'h05; 37: d = 8'h24; 38: d = 8'h00; 39: d = 8'h10;
            40: d = 8'h01;
            41: d = 8'h04; 42: d = 8'h24; 43: d = 8'h02; 44: d = 8'h00;
            45: d = 8'h05; 46: d = 8'h24; 47: d = 8'h06; 48: d = 8'h00;
            49: d = 8'h01;
            50: d = 8'h05; 51: d = 8'h24; 52: d = 8'h01; 53: d = 8'h00;
            54: d = 8'h01;
            55: d = 8'h07; 56: d = 8'h05; 57: d = 8'h83; 58: d = 8'h03;
            59: d = 8'h08; 60: d = 8'h00; 61: d = 8'hFF;
            62: d = 8'h09; 63: d = 8'h04; 64: d = 8'h01; 65: d = 8'h00;
            66: d = 8'h02; 67: d = 8'h0A; 68: d = 8'h00; 69: d = 8'h00;
            70: d = 8'h00;
            71: d = 8'h07; 72: d = 8'h05; 73: d = 8'h01; 74: d = 8'h02;
            75: d = 8'h40; 76: d = 8'h00; 77: d = 8'h00;
            78: d = 8'h07; 79: d = 8'h05; 80: d = 8'h82; 81: d = 8'h02;
            82: d = 8'h40; 83: d = 8'h00; 84: d = 8'h00;
            85: d = 8'h04; 86: d = 8'h03; 87: d = 8'h09; 88: d = 8'h04;
            89: d = 8'h1A; 90: d = 8'h03; 91: d = 8'h54; 93: d = 8'h69;
            95: d = 8'h6C; 97: d = 8'h6C; 99: d = 8'h20; 101: d = 8'h48;
            103: d = 8'h61; 105: d = 8'h72; 107: d = 8'h62; 109: d = 8'h61;
            111: d = 8'h75; 113: d = 8'h6D;
            115: d = 8'h16; 116: d = 8'h03; 117: d = 8'h4D; 119: d = 8'h49;
            121: d = 8'h53; 123: d = 8'h54; 125: d = 8'h20; 127: d = 8'h42;
            129: d = 8'h6F; 131: d = 8'h61; 133: d = 8'h72; 135: d = 8'h64;
            default: d = 8'h00;
        endcase
        return d;
    endfunction

endpackage

// ----- hdl/usb_cdc_control_request_responder.sv -----
// ----------------------------------------------------------------------------
// usb_cdc_control_request_responder
// answers usb setup requests for a cdc device, packets from a descriptor rom
// ----------------------------------------------------------------------------
//   channel | direction | handshake              | payload
//   in      | input     | i_in_valid/o_in_ready   | t_in_item
//   out     | output    | o_out_valid/i_out_ready | t_out_item
//   cfg     | input     | i_cfg_valid/o_cfg_ready | index 2 bits, data 32 bits
//
// the sender reads the rom one byte a cycle, and a full configuration
// descriptor is sent as 9 packets.
// synchronous active-low reset; no clearing pass. a two-entry queue lets the
// decoder keep taking transactions while the output side stalls.
module usb_cdc_control_request_responder (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  ucdc_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output ucdc_pkg::t_out_item o_out_data,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [1:0]          i_cfg_index,
    input  logic [31:0]         i_cfg_data
);
    import ucdc_pkg::*;

    logic q_wr_valid, q_wr_ready, q_rd_valid, q_rd_ready;
    t_job q_wr_job, q_rd_job;

    ucdc_front u_front (
        .i_clk, .i_rst_n, .i_in_valid, .o_in_ready, .i_in_data,
        .i_cfg_valid, .o_cfg_ready, .i_cfg_index, .i_cfg_data,
        .o_job_valid(q_wr_valid), .i_job_ready(q_wr_ready), .o_job(q_wr_job)
    );

    ucdc_queue u_queue (
        .i_clk, .i_rst_n,
        .i_wr_valid(q_wr_valid), .o_wr_ready(q_wr_ready), .i_wr_job(q_wr_job),
        .o_rd_valid(q_rd_valid), .i_rd_ready(q_rd_ready), .o_rd_job(q_rd_job)
    );

    ucdc_back u_back (
        .i_clk, .i_rst_n,
        .i_job_valid(q_rd_valid), .o_job_ready(q_rd_ready), .i_job(q_rd_job),
        .o_out_valid, .i_out_ready, .o_out_data
    );
endmodule

// ----- hdl/ucdc_front.sv -----
// ----------------------------------------------------------------------------
// ucdc_front
// decodes setup transactions, updates device state and emits one job each
// ----------------------------------------------------------------------------
module ucdc_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  ucdc_pkg::t_in_item i_in_data,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    output logic               o_job_valid,
    input  logic               i_job_ready,
    output ucdc_pkg::t_job     o_job
);
    import ucdc_pkg::*;

    logic [31:0] r_baud;
    logic [1:0]  r_stop;
    logic [2:0]  r_parity;
    logic [4:0]  r_dbits;
    logic [6:0]  r_addr, n_addr;
    logic        r_addressed, n_addressed;
    logic        r_configured, n_configured;
    logic [7:0]  r_config, n_config;
    logic [7:0]  r_line, n_line;
    logic [NUM_ENDPOINTS-1:0] r_ep_en, n_ep_en;
    t_job        n_job;

    logic [15:0] key;
    logic [15:0] wval;
    logic [3:0]  ep;
    logic [15:0] wlen;
    logic        ep_ok;
    logic        ep_st_en;

    assign o_in_ready  = i_job_ready;
    assign o_job_valid = i_in_valid;
    assign o_cfg_ready = 1'b1;

    assign key  = {i_in_data.request_code, i_in_data.request_type};
    assign wval = i_in_data.request_value;
    assign ep   = i_in_data.request_index[3:0];
    assign wlen = i_in_data.request_length;
    assign ep_ok = (32'(ep) < NUM_ENDPOINTS);
    assign ep_st_en = ep_ok ? r_ep_en[ep[EP_W-1:0]] : 1'b0;

    function automatic logic [6:0] clip(input logic [6:0] sz, input logic [15:0] lim);
        return (16'(sz) < lim) ? sz : lim[6:0];
    endfunction

    always_comb begin
        n_addr       = r_addr;
        n_addressed  = r_addressed;
        n_configured = r_configured;
        n_config     = r_config;
        n_line       = r_line;
        n_ep_en      = r_ep_en;
        n_job        = '0;
        n_job.action = ACT_STALL;
        n_job.source = SRC_NONE;
        if (i_in_data.command[0]) begin
            n_addr       = '0;
            n_addressed  = 1'b0;
            n_configured = 1'b0;
            n_config     = '0;
            n_ep_en      = NUM_ENDPOINTS'(1);
            n_job.action = ACT_RESET;
        end else begin
            case (key)
                KEY_GET_DESC: begin
                    n_job.action = ACT_DATA;
                    n_job.source = SRC_ROM;
                    case (wval)
                        DESC_DEV: begin
                            n_job.offset = OFS_DEV;  n_job.count = clip(LEN_DEV, wlen);
                        end
                        DESC_CFG: begin
                            n_job.offset = OFS_CFG;  n_job.count = clip(LEN_CFG, wlen);
                        end
                        DESC_LANG: begin
                            n_job.offset = OFS_LANG; n_job.count = clip(LEN_LANG, wlen);
                        end
                        DESC_MFR: begin
                            n_job.offset = OFS_MFR;  n_job.count = clip(LEN_MFR, wlen);
                        end
                        DESC_PROD: begin
                            n_job.offset = OFS_PROD; n_job.count = clip(LEN_PROD, wlen);
                        end
                        default: begin
                            n_job.action = ACT_STALL;
                            n_job.source = SRC_NONE;
                        end
                    endcase
                end
                KEY_SET_ADDR: begin
                    n_addr       = wval[6:0];
                    n_addressed  = (wval != 16'd0);
                    n_configured = 1'b0;
                    n_job.action = ACT_ZLP;
                end
                KEY_SET_CONFIG: begin
                    n_config     = wval[7:0];
                    n_configured = (wval != 16'd0);
                    n_addressed  = 1'b1;
                    n_ep_en      = {{(NUM_ENDPOINTS-1){wval != 16'd0}}, r_ep_en[0]};
                    n_job.action = ACT_ZLP;
                end
                KEY_GET_CONFIG: begin
                    n_job.action   = ACT_DATA;
                    n_job.source   = SRC_BUF;
                    n_job.count    = 7'd1;
                    n_job.buf_data = {48'd0, r_config};
                end
                KEY_GST_DEV, KEY_GST_IF: begin
                    n_job.action = ACT_DATA;
                    n_job.source = SRC_BUF;
                    n_job.count  = 7'd2;
                end
                KEY_GST_EP: begin
                    if ((r_configured && ep_ok) || (r_addressed && ep == 4'd0)) begin
                        n_job.action   = ACT_DATA;
                        n_job.source   = SRC_BUF;
                        n_job.count    = 7'd2;
                        n_job.buf_data = {55'd0, ~ep_st_en};
                    end
                end
                KEY_SF_IF, KEY_CF_IF, KEY_SET_LC: n_job.action = ACT_ZLP;
                KEY_SF_EP, KEY_CF_EP: begin
                    if (wval == 16'd0 && ep != 4'd0 && ep_ok) begin
                        n_ep_en[ep[EP_W-1:0]] = (i_in_data.request_code == 8'h01);
                        n_job.action = ACT_ZLP;
                    end
                end
                KEY_GET_LC: begin
                    n_job.action   = ACT_DATA;
                    n_job.source   = SRC_BUF;
                    n_job.count    = clip(LEN_LC, wlen);
                    n_job.buf_data = {3'd0, r_dbits, 5'd0, r_parity, 6'd0, r_stop, r_baud};
                end
                KEY_SET_CLS: begin
                    n_line       = wval[7:0];
                    n_job.action = ACT_ZLP;
                end
                default: n_job.action = ACT_STALL;
            endcase
        end
        n_job.device_address      = n_addr;
        n_job.configuration_value = n_config;
        n_job.control_line_state  = n_line;
    end

    assign o_job = n_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr       <= '0;
            r_addressed  <= 1'b0;
            r_configured <= 1'b0;
            r_config     <= '0;
            r_line       <= '0;
            r_ep_en      <= NUM_ENDPOINTS'(1);
            r_baud       <= 32'd115200;
            r_stop       <= '0;
            r_parity     <= '0;
            r_dbits      <= 5'd8;
        end else begin
            if (i_in_valid && i_job_ready) begin
                r_addr       <= n_addr;
                r_addressed  <= n_addressed;
                r_configured <= n_configured;
                r_config     <= n_config;
                r_line       <= n_line;
                r_ep_en      <= n_ep_en;
            end
            if (i_cfg_valid) begin
                unique case (t_reg_index'(i_cfg_index))
                    REG_BAUD:   r_baud   <= i_cfg_data;
                    REG_STOP:   r_stop   <= i_cfg_data[1:0];
                    REG_PARITY: r_parity <= i_cfg_data[2:0];
                    REG_DBITS:  r_dbits  <= i_cfg_data[4:0];
                    default:    r_baud   <= r_baud;
                endcase
            end
        end
    end
endmodule

// ----- hdl/ucdc_queue.sv -----
// ----------------------------------------------------------------------------
// ucdc_queue
// two-entry job queue between decoder and packet sender
// ----------------------------------------------------------------------------
module ucdc_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr_valid,
    output logic           o_wr_ready,
    input  ucdc_pkg::t_job i_wr_job,
    output logic           o_rd_valid,
    input  logic           i_rd_ready,
    output ucdc_pkg::t_job o_rd_job
);
    import ucdc_pkg::*;

    t_job       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       wr, rd;

    assign o_wr_ready = (r_cnt != 2'd2);
    assign o_rd_valid = (r_cnt != 2'd0);
    assign wr = i_wr_valid && o_wr_ready;
    assign rd = o_rd_valid && i_rd_ready;
    assign o_rd_job = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (wr) r_mem[r_wp] <= i_wr_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (wr) r_wp <= ~r_wp;
            if (rd) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(wr) - 2'(rd);
        end
    end
endmodule

// ----- hdl/ucdc_back.sv -----
// ----------------------------------------------------------------------------
// ucdc_back
// splits a job into 8-byte packets, fetching rom bytes one per cycle
// ----------------------------------------------------------------------------
module ucdc_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_job_valid,
    output logic                o_job_ready,
    input  ucdc_pkg::t_job      i_job,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output ucdc_pkg::t_out_item o_out_data
);
    import ucdc_pkg::*;

    t_back_state       r_state, n_state;
    t_job              r_job;
    logic [ROM_AW-1:0] r_ptr;
    logic [6:0]        r_left;
    logic [3:0]        r_chunk;
    logic [2:0]        r_idx;
    logic [63:0]       r_pkt;
    logic [3:0]        chunk_now;

    assign chunk_now = (r_left < 7'd8) ? r_left[3:0] : 4'd8;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE:  if (i_job_valid) n_state = BK_LOAD;
            BK_LOAD:  n_state = (r_job.source == SRC_ROM && chunk_now != 4'd0)
                                ? BK_FETCH : BK_SEND;
            BK_FETCH: if (4'(r_idx) + 4'd1 == r_chunk) n_state = BK_SEND;
            BK_SEND:  if (i_out_ready) n_state = (r_left == 7'd0) ? BK_IDLE : BK_LOAD;
            default:  n_state = BK_IDLE;
        endcase
    end

    always_comb begin
        o_job_ready = (r_state == BK_IDLE);
        o_out_valid = (r_state == BK_SEND);
        o_out_data.action              = r_job.action;
        o_out_data.packet_data         = r_pkt;
        o_out_data.packet_bytes        = r_chunk;
        o_out_data.last                = (r_left == 7'd0);
        o_out_data.device_address      = r_job.device_address;
        o_out_data.configuration_value = r_job.configuration_value;
        o_out_data.control_line_state  = r_job.control_line_state;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            BK_IDLE: begin
                if (i_job_valid) begin
                    r_job  <= i_job;
                    r_ptr  <= i_job.offset;
                    r_left <= i_job.count;
                end
            end
            BK_LOAD: begin
                r_chunk <= chunk_now;
                r_left  <= r_left - 7'(chunk_now);
                r_idx   <= '0;
                if (r_job.source == SRC_BUF) begin
                    r_pkt <= 64'(r_job.buf_data & ~(56'hFF_FFFF_FFFF_FFFF << (8 * chunk_now)));
                end else begin
                    r_pkt <= '0;
                end
            end
            BK_FETCH: begin
                r_pkt[8*r_idx +: 8] <= rom_byte(r_ptr);
                r_ptr <= r_ptr + ROM_AW'(1);
                r_idx <= r_idx + 3'd1;
            end
            BK_SEND: ;
            default: ;
        endcase
    end
endmodule

// ----- hdl/ucdc_checker.sv -----
// ----------------------------------------------------------------------------
// ucdc_checker
// port-level checks on the responder's result stream
// ----------------------------------------------------------------------------
module ucdc_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input ucdc_pkg::t_out_item o_out_data
);
    import ucdc_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    a_bytes_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.packet_bytes <= 4'd8)
        else $error("packet longer than eight bytes");

    a_nodata_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.action != ACT_DATA |->
            o_out_data.packet_bytes == 4'd0 && o_out_data.last == 1'b1)
        else $error("handshake result carries bytes or is not last");

    a_short_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.packet_bytes != 4'd8 |-> o_out_data.last == 1'b1)
        else $error("short packet not marked last");
endmodule

bind usb_cdc_control_request_responder ucdc_checker u_checker (
    .i_clk, .i_rst_n, .o_out_valid, .i_out_ready, .o_out_data
);

// ----- tb/tb_usb_cdc_control_request_responder.sv -----
// ----------------------------------------------------------------------------
// tb_usb_cdc_control_request_responder
// drives setup requests and bus resets through the responder and checks every
// packet against an in-bench prediction of device state and descriptor data
// ----------------------------------------------------------------------------
module tb_usb_cdc_control_request_responder;
    import ucdc_pkg::*;

    localparam int ROM_LEN = 137;
    localparam logic [7:0] DESC_BYTES [0:ROM_LEN-1] = '{
        8'h12, 8'h01, 8'h10, 8'h01, 8'h02, 8'h00, 8'h00, 8'h08, 8'h40, 8'h1C,
        8'h37, 8'h05, 8'h01, 8'h00, 8'h01, 8'h02, 8'h00, 8'h01,
        8'h09, 8'h02, 8'h43, 8'h00, 8'h02, 8'h01, 8'h00, 8'hC0, 8'hC8,
        8'h09, 8'h04, 8'h00, 8'h00, 8'h01, 8'h02, 8'h02, 8'h00, 8'h00,
        8'h05, 8'h24, 8'h00, 8'h10, 8'h01,
        8'h04, 8'h24, 8'h02, 8'h00,
        8'h05, 8'h24, 8'h06, 8'h00, 8'h01,
        8'h05, 8'h24, 8'h01, 8'h00, 8'h01,
        8'h07, 8'h05, 8'h83, 8'h03, 8'h08, 8'h00, 8'hFF,
        8'h09, 8'h04, 8'h01, 8'h00, 8'h02, 8'h0A, 8'h00, 8'h00, 8'h00,
        8'h07, 8'h05, 8'h01, 8'h02, 8'h40, 8'h00, 8'h00,
        8'h07, 8'h05, 8'h82, 8'h02, 8'h40, 8'h00, 8'h00,
        8'h04, 8'h03, 8'h09, 8'h04,
        8'h1A, 8'h03, 8'h54, 8'h00, 8'h69, 8'h00, 8'h6C, 8'h00, 8'h6C, 8'h00,
        8'h20, 8'h00, 8'h48, 8'h00, 8'h61, 8'h00, 8'h72, 8'h00, 8'h62, 8'h00,
        8'h61, 8'h00, 8'h75, 8'h00, 8'h6D, 8'h00,
        8'h16, 8'h03, 8'h4D, 8'h00, 8'h49, 8'h00, 8'h53, 8'h00, 8'h54, 8'h00,
        8'h20, 8'h00, 8'h42, 8'h00, 8'h6F, 8'h00, 8'h61, 8'h00, 8'h72, 8'h00,
        8'h64, 8'h00
    };

    localparam logic [15:0] KEYS [0:15] = '{
        KEY_GET_DESC, KEY_SET_ADDR, KEY_SET_CONFIG, KEY_GET_CONFIG,
        KEY_GST_DEV, KEY_GST_IF, KEY_GST_EP, KEY_SF_DEV, KEY_CF_DEV,
        KEY_SF_IF, KEY_CF_IF, KEY_SF_EP, KEY_CF_EP, KEY_SET_LC,
        KEY_GET_LC, KEY_SET_CLS
    };

    class packet_scoreboard;
        t_out_item   expected_q[$];
        int          errors;
        logic [31:0] baud;
        logic [1:0]  stop_bits;
        logic [2:0]  parity;
        logic [4:0]  data_bits;
        logic [6:0]  address;
        bit          addressed;
        bit          configured;
        logic [7:0]  config_value;
        logic [7:0]  line_state;
        bit          ep_enabled [NUM_ENDPOINTS];

        function new();
            errors = 0;
            baud = 32'd115200;
            stop_bits = '0;
            parity = '0;
            data_bits = 5'd8;
            address = '0;
            addressed = 0;
            configured = 0;
            config_value = '0;
            line_state = '0;
            foreach (ep_enabled[i]) ep_enabled[i] = (i == 0);
        endfunction

        function void write_reg(t_reg_index idx, logic [31:0] d);
            case (idx)
                REG_BAUD:   baud = d;
                REG_STOP:   stop_bits = d[1:0];
                REG_PARITY: parity = d[2:0];
                REG_DBITS:  data_bits = d[4:0];
                default: ;
            endcase
        endfunction

        function void push_result(t_action act, logic [63:0] d, int n, bit fin);
            t_out_item r;
            r.action = act;
            r.packet_data = d;
            r.packet_bytes = 4'(n);
            r.last = fin;
            r.device_address = address;
            r.configuration_value = config_value;
            r.control_line_state = line_state;
            expected_q.push_back(r);
        endfunction

        // split a reply into packets, always at least one
        function void push_bytes(logic [7:0] b[$]);
            int pos, n, c;
            logic [63:0] d;
            pos = 0;
            n = b.size();
            do begin
                c = (n < CTRL_PACKET_BYTES) ? n : CTRL_PACKET_BYTES;
                d = '0;
                for (int i = 0; i < c; i++) d[8*i +: 8] = b[pos + i];
                n -= c;
                pos += c;
                push_result(ACT_DATA, d, c, n == 0);
            end while (n != 0);
        endfunction

        function void push_rom(int ofs, int size, int limit);
            logic [7:0] b[$];
            for (int i = 0; i < ((size < limit) ? size : limit); i++)
                b.push_back(DESC_BYTES[ofs + i]);
            push_bytes(b);
        endfunction

        function void note_input(t_in_item it);
            logic [15:0] key;
            logic [15:0] val;
            int          ep;
            int          len;
            logic [7:0]  b[$];
            key = {it.request_code, it.request_type};
            val = it.request_value;
            ep  = int'(it.request_index[3:0]);
            len = int'(it.request_length);
            if (it.command) begin
                address = '0;
                addressed = 0;
                configured = 0;
                config_value = '0;
                foreach (ep_enabled[i]) ep_enabled[i] = (i == 0);
                push_result(ACT_RESET, '0, 0, 1);
                return;
            end
            case (key)
                KEY_GET_DESC: begin
                    case (val)
                        DESC_DEV:  push_rom(0, 18, len);
                        DESC_CFG:  push_rom(18, 67, len);
                        DESC_LANG: push_rom(85, 4, len);
                        DESC_MFR:  push_rom(89, 26, len);
                        DESC_PROD: push_rom(115, 22, len);
                        default:   push_result(ACT_STALL, '0, 0, 1);
                    endcase
                end
                KEY_SET_ADDR: begin
                    address = val[6:0];
                    addressed = (val != 0);
                    configured = 0;
                    push_result(ACT_ZLP, '0, 0, 1);
                end
                KEY_SET_CONFIG: begin
                    config_value = val[7:0];
                    configured = (val != 0);
                    addressed = 1;
                    for (int i = 1; i < NUM_ENDPOINTS; i++) ep_enabled[i] = (val != 0);
                    push_result(ACT_ZLP, '0, 0, 1);
                end
                KEY_GET_CONFIG: begin
                    b.push_back(config_value);
                    push_bytes(b);
                end
                KEY_GST_DEV, KEY_GST_IF: begin
                    b = '{8'h00, 8'h00};
                    push_bytes(b);
                end
                KEY_GST_EP: begin
                    if ((configured && ep < NUM_ENDPOINTS) || (addressed && ep == 0)) begin
                        b = '{ep_enabled[ep] ? 8'h00 : 8'h01, 8'h00};
                        push_bytes(b);
                    end else begin
                        push_result(ACT_STALL, '0, 0, 1);
                    end
                end
                KEY_SF_DEV, KEY_CF_DEV: push_result(ACT_STALL, '0, 0, 1);
                KEY_SF_IF, KEY_CF_IF:   push_result(ACT_ZLP, '0, 0, 1);
                KEY_SF_EP, KEY_CF_EP: begin
                    if (val == 0 && ep != 0 && ep < NUM_ENDPOINTS) begin
                        ep_enabled[ep] = (key == KEY_CF_EP);
                        push_result(ACT_ZLP, '0, 0, 1);
                    end else begin
                        push_result(ACT_STALL, '0, 0, 1);
                    end
                end
                KEY_SET_LC: push_result(ACT_ZLP, '0, 0, 1);
                KEY_GET_LC: begin
                    b = '{baud[7:0], baud[15:8], baud[23:16], baud[31:24],
                          8'(stop_bits), 8'(parity), 8'(data_bits)};
                    while (b.size() > len) void'(b.pop_back());
                    push_bytes(b);
                end
                KEY_SET_CLS: begin
                    line_state = val[7:0];
                    push_result(ACT_ZLP, '0, 0, 1);
                end
                default: push_result(ACT_STALL, '0, 0, 1);
            endcase
        endfunction

        function void compare(string name, logic [63:0] e, logic [63:0] a);
            if (e !== a) begin
                $error("%s: expected %0h, got %0h", name, e, a);
                errors++;
            end
        endfunction

        function void check_result(t_out_item got);
            t_out_item e;
            if (expected_q.size() == 0) begin
                $error("result with nothing expected: %0h", got);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            compare("action", 64'(e.action), 64'(got.action));
            compare("packet_data", e.packet_data, got.packet_data);
            compare("packet_bytes", 64'(e.packet_bytes), 64'(got.packet_bytes));
            compare("last", 64'(e.last), 64'(got.last));
            compare("device_address", 64'(e.device_address), 64'(got.device_address));
            compare("configuration_value", 64'(e.configuration_value),
                    64'(got.configuration_value));
            compare("control_line_state", 64'(e.control_line_state),
                    64'(got.control_line_state));
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_in_valid = 0;
    logic        o_in_ready;
    t_in_item    i_in_data = '0;
    logic        o_out_valid;
    logic        i_out_ready = 0;
    t_out_item   o_out_data;
    logic        i_cfg_valid = 0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;

    packet_scoreboard sb = new();
    int in_idle = 0;
    int out_stall = 0;

    usb_cdc_control_request_responder u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) sb.check_result(o_out_data);
        i_out_ready <= ($urandom_range(99) >= out_stall);
    end

    initial begin
        #20000000;
        $display("end of test: mismatches");
        $finish;
    end

    // valid is only lowered when a gap follows, so back-to-back items keep it high
    task automatic send_request(t_in_item it);
        if ($urandom_range(99) < in_idle) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < in_idle) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= it;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_input(it);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic write_reg(t_reg_index idx, logic [31:0] d);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= d;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, d);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_line_coding(logic [31:0] baud, logic [1:0] sb_code,
                                     logic [2:0] par, logic [4:0] dbits);
        write_reg(REG_BAUD, baud);
        write_reg(REG_STOP, 32'(sb_code));
        write_reg(REG_PARITY, 32'(par));
        write_reg(REG_DBITS, 32'(dbits));
    endtask

    function automatic t_in_item make_setup(logic [15:0] key, logic [15:0] val,
                                            logic [15:0] idx, logic [15:0] len);
        t_in_item it;
        it.command = 1'b0;
        {it.request_code, it.request_type} = key;
        it.request_value = val;
        it.request_index = idx;
        it.request_length = len;
        return it;
    endfunction

    function automatic t_in_item random_request();
        t_in_item it;
        int k;
        it = t_in_item'({$urandom, $urandom, $urandom});
        k = $urandom_range(99);
        if (k < 8) begin
            it.command = 1'b1;
        end else if (k >= 18) begin
            it.command = 1'b0;
            {it.request_code, it.request_type} = KEYS[$urandom_range(15)];
            if ($urandom_range(4) != 0) it.request_index[3:0] = 4'($urandom_range(5));
            if ($urandom_range(4) != 0) it.request_length = 16'($urandom_range(80));
            case ({it.request_code, it.request_type})
                KEY_GET_DESC: begin
                    case ($urandom_range(5))
                        0: it.request_value = DESC_DEV;
                        1: it.request_value = DESC_CFG;
                        2: it.request_value = DESC_LANG;
                        3: it.request_value = DESC_MFR;
                        4: it.request_value = DESC_PROD;
                        default: ;
                    endcase
                end
                KEY_SET_CONFIG:
                    if ($urandom_range(1)) it.request_value = 16'($urandom_range(1));
                KEY_SF_EP, KEY_CF_EP:
                    if ($urandom_range(4) != 0) it.request_value = '0;
                default: ;
            endcase
        end else begin
            it.command = 1'b0;
        end
        return it;
    endfunction

    initial begin
        t_in_item dir[$];
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        dir.push_back(t_in_item'({1'b1, 64'hFFFF_FFFF_FFFF_FFFF}));
        dir.push_back(make_setup(KEY_GET_DESC, DESC_DEV, 16'h0000, 16'hFFFF));
        dir.push_back(make_setup(KEY_GET_DESC, DESC_CFG, 16'h0000, 16'd67));
        dir.push_back(make_setup(KEY_GET_DESC, DESC_CFG, 16'h0000, 16'd0));
        dir.push_back(make_setup(KEY_GET_DESC, DESC_LANG, 16'h0000, 16'd255));
        dir.push_back(make_setup(KEY_GET_DESC, DESC_MFR, 16'h0000, 16'd9));
        dir.push_back(make_setup(KEY_GET_DESC, DESC_PROD, 16'h0000, 16'd64));
        dir.push_back(make_setup(KEY_GET_DESC, 16'h0303, 16'h0000, 16'd64));
        dir.push_back(make_setup(KEY_GST_EP, 16'h0000, 16'h0000, 16'd2));
        dir.push_back(make_setup(KEY_SET_ADDR, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        dir.push_back(make_setup(KEY_GST_EP, 16'h0000, 16'h0002, 16'd2));
        dir.push_back(make_setup(KEY_SET_CONFIG, 16'h0001, 16'h0000, 16'd0));
        dir.push_back(make_setup(KEY_GET_CONFIG, 16'h0000, 16'h0000, 16'd0));
        dir.push_back(make_setup(KEY_SF_EP, 16'h0000, 16'h0002, 16'd0));
        dir.push_back(make_setup(KEY_GST_EP, 16'h0000, 16'h0002, 16'd2));
        dir.push_back(make_setup(KEY_CF_EP, 16'h0000, 16'h0002, 16'd0));
        dir.push_back(make_setup(KEY_SF_EP, 16'h0000, 16'h0000, 16'd0));
        dir.push_back(make_setup(KEY_CF_EP, 16'h0001, 16'h0003, 16'd0));
        dir.push_back(make_setup(KEY_SF_EP, 16'h0000, 16'h0004, 16'd0));
        dir.push_back(make_setup(KEY_GST_DEV, 16'h0000, 16'h0000, 16'd0));
        dir.push_back(make_setup(KEY_SF_DEV, 16'h0001, 16'h0000, 16'd0));
        dir.push_back(make_setup(KEY_CF_IF, 16'h0000, 16'h0000, 16'd0));
        dir.push_back(make_setup(KEY_SET_CLS, 16'hA5FF, 16'h0000, 16'd0));
        dir.push_back(make_setup(KEY_GET_LC, 16'h0000, 16'h0000, 16'd3));
        dir.push_back(make_setup(16'hFFFF, 16'h0000, 16'h0000, 16'd8));
        foreach (dir[i]) send_request(dir[i]);
        drain();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin in_idle = 0;  out_stall = 0;  write_line_coding('0, 2'd0, 3'd0, 5'd5); end
                1: begin in_idle = 86; out_stall = 0;
                   write_line_coding(32'hFFFF_FFFF, 2'd2, 3'd4, 5'd16); end
                2: begin in_idle = 0;  out_stall = 86;
                   write_line_coding($urandom, 2'($urandom_range(2)), 3'($urandom_range(4)),
                                     5'($urandom_range(5, 16))); end
                default: begin in_idle = 33; out_stall = 33;
                   write_line_coding(32'h5555_AAAA, 2'd1, 3'd2, 5'd8); end
            endcase
            send_request(make_setup(KEY_GET_LC, 16'h0000, 16'h0000, 16'hFFFF));
            for (int n = 0; n < 70; n++) begin
                send_request(random_request());
                // let everything drain once before continuing
                if (phase == 0 && n == 35) drain();
            end
            drain();
        end

        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule
